/* design/gpc_pkg.sv */
// Shared types, constants and codes of the genotype and popcount counter.
package gpc_pkg;

    localparam int DEF_MAX_WORDS = 1024;
    localparam int GENOTYPES     = 3;
    localparam int WORD_W        = 64;
    localparam int GENO_W        = 2;
    localparam int ROW_W         = 12;
    localparam int WIDX_W        = 10;
    localparam int CNT_W         = 17;
    localparam int PC_W          = 7;
    localparam int CFG_W         = 11;
    localparam int CFG_IDX_W     = 1;
    localparam int S_TDATA_W     = 88;
    localparam int S_TUSER_W     = 2;
    localparam int M_TDATA_W     = 64;

    localparam logic [CNT_W-1:0]  ACC_MAX       = '1;
    localparam logic [GENO_W-1:0] GENO_COUNT    = GENO_W'(GENOTYPES);

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_STREAM = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CASE_COUNT    = 1'b0,
        REG_CONTROL_COUNT = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        CLASS_CASE    = 1'b0,
        CLASS_CONTROL = 1'b1
    } class_t;

    // streamed word on its way to the accumulators
    typedef struct packed {
        logic             valid;
        logic             sample_class;
        logic [ROW_W-1:0] row;
        logic             last;
        logic             hit;
    } stream_info_t;

    // status handed back from the accumulator stage
    typedef struct packed {
        logic adv;
        logic emit;
        logic acc_zero;
    } acc_status_t;

endpackage

/* design/gpc_store.sv */
// Second-table store: one synchronous bank per genotype, registered read.
module gpc_store #(
    parameter int  MAX_WORDS = gpc_pkg::DEF_MAX_WORDS,
    localparam int WidxW     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1,
    localparam int AddrW     = WidxW + 1
) (
    input  logic                                             aclk,
    input  logic                                             wr_en,
    input  logic [gpc_pkg::GENO_W-1:0]                       wr_geno,
    input  logic [AddrW-1:0]                                 wr_addr,
    input  logic [gpc_pkg::WORD_W-1:0]                       wr_data,
    input  logic                                             rd_en,
    input  logic [AddrW-1:0]                                 rd_addr,
    output logic [gpc_pkg::GENOTYPES-1:0][gpc_pkg::WORD_W-1:0] rd_data
);

    localparam int Depth = 2 * (1 << WidxW);

    for (genvar g = 0; g < gpc_pkg::GENOTYPES; g++) begin : g_bank
        logic [gpc_pkg::WORD_W-1:0] mem [Depth];
        logic [gpc_pkg::WORD_W-1:0] rd_reg;

        always_ff @(posedge aclk) begin
            if (wr_en && (wr_geno == gpc_pkg::GENO_W'(g))) begin
                mem[wr_addr] <= wr_data;
            end
            if (rd_en) begin
                rd_reg <= mem[rd_addr];
            end
        end

        assign rd_data[g] = rd_reg;
    end

endmodule

/* design/gpc_accum.sv */
// AND and popcount stage, three saturating accumulators and the result register.
module gpc_accum (
    input  logic                                               aclk,
    input  logic                                               aresetn,
    input  gpc_pkg::stream_info_t                              s1_info,
    input  logic [gpc_pkg::WORD_W-1:0]                         s1_data,
    input  logic [gpc_pkg::GENOTYPES-1:0][gpc_pkg::WORD_W-1:0] rd_data,
    input  logic                                               m_tready,
    output logic                                               m_tvalid,
    output logic [gpc_pkg::M_TDATA_W-1:0]                      m_tdata,
    output logic                                               m_tuser,
    output gpc_pkg::acc_status_t                               status
);

    localparam int CW = gpc_pkg::CNT_W;

    function automatic logic [gpc_pkg::PC_W-1:0] ones_in(input logic [gpc_pkg::WORD_W-1:0] v);
        logic [3:0]               byte_cnt;
        logic [gpc_pkg::PC_W-1:0] total;
        total = '0;
        for (int b = 0; b < gpc_pkg::WORD_W / 8; b++) begin
            byte_cnt = '0;
            for (int i = 0; i < 8; i++) begin
                byte_cnt = byte_cnt + 4'(v[b*8+i]);
            end
            total = total + gpc_pkg::PC_W'(byte_cnt);
        end
        return total;
    endfunction

    gpc_pkg::stream_info_t                                s2_info_reg;
    logic [gpc_pkg::GENOTYPES-1:0][gpc_pkg::PC_W-1:0]     pc_reg, pc_next;
    logic [gpc_pkg::GENOTYPES-1:0][CW-1:0]                acc_reg, acc_next, sum;
    logic [gpc_pkg::GENOTYPES-1:0][CW-1:0]                out_cnt_reg;
    logic                                                 out_valid_reg;
    logic                                                 out_class_reg;
    logic [gpc_pkg::ROW_W-1:0]                            out_row_reg;
    logic                                                 adv;
    logic                                                 emit;

    assign adv  = !out_valid_reg || m_tready;
    assign emit = s2_info_reg.valid && s2_info_reg.last;

    always_comb begin
        for (int g = 0; g < gpc_pkg::GENOTYPES; g++) begin
            pc_next[g] = s1_info.hit ? ones_in(s1_data & rd_data[g]) : '0;
        end
    end

    // saturating add; a finished row clears its accumulator
    always_comb begin
        logic [CW:0] wide;
        for (int g = 0; g < gpc_pkg::GENOTYPES; g++) begin
            wide   = {1'b0, acc_reg[g]} + (CW+1)'(pc_reg[g]);
            sum[g] = wide[CW] ? gpc_pkg::ACC_MAX : wide[CW-1:0];
            if (!s2_info_reg.valid) begin
                acc_next[g] = acc_reg[g];
            end else if (s2_info_reg.last) begin
                acc_next[g] = '0;
            end else begin
                acc_next[g] = sum[g];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_info_reg.valid <= 1'b0;
            acc_reg           <= '0;
            out_valid_reg     <= 1'b0;
        end else if (adv) begin
            s2_info_reg   <= s1_info;
            acc_reg       <= acc_next;
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pc_reg <= pc_next;
            if (emit) begin
                out_class_reg <= s2_info_reg.sample_class;
                out_row_reg   <= s2_info_reg.row;
                out_cnt_reg   <= sum;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_class_reg;
    assign m_tdata  = gpc_pkg::M_TDATA_W'({out_cnt_reg[2], out_cnt_reg[1], out_cnt_reg[0],
                                           out_row_reg});

    assign status.adv      = adv;
    assign status.emit     = emit;
    assign status.acc_zero = (acc_reg == '0);

endmodule

/* design/genotype_and_popcount_counter_unit.sv */
// Top level of the genotype and popcount counter: decode, config, store read stage.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tuser: operation, sample_class; tdata: words
//  m_      | out | m_tvalid/m_tready  | tuser: out_class; tdata: row and three counts
//  cfg_    | in  | cfg_wr_en          | cfg_index, cfg_wr_data (word counts)
//
// One transfer per cycle sustained on the input while no result waits on m_tready;
// loads and streamed words may be mixed freely. A streamed row end raises m_tvalid
// after store read at its transfer, AND/popcount, then accumulate into output register.
// Reset is synchronous: clears pipeline valids, accumulators and word counts (to one).
// The store has no clearing pass; entries are undefined until loaded.
// A result waiting on m_tready holds the whole pipeline, so s_tready drops with it.
module genotype_and_popcount_counter_unit #(
    parameter int MAX_WORDS = gpc_pkg::DEF_MAX_WORDS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // slave side
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [1:0] genotype, [13:2] row_index, [23:14] word_index, [87:24] data_word
    input  logic [gpc_pkg::S_TDATA_W-1:0]     s_tdata,
    // [0] operation, [1] sample_class
    input  logic [gpc_pkg::S_TUSER_W-1:0]     s_tuser,
    // master side
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [11:0] out_row, [28:12] count_g0, [45:29] count_g1, [62:46] count_g2, [63] zero
    output logic [gpc_pkg::M_TDATA_W-1:0]     m_tdata,
    // [0] out_class
    output logic                              m_tuser,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [gpc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gpc_pkg::CFG_W-1:0]         cfg_wr_data
);

    localparam int WidxW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int AddrW = WidxW + 1;

    // last word index of a row, from a written word count clamped to 1..MAX_WORDS
    function automatic logic [WidxW-1:0] last_of(input logic [gpc_pkg::CFG_W-1:0] cnt);
        logic [31:0] c;
        c = 32'(cnt);
        if (c == 32'd0) begin
            return '0;
        end else if (c > 32'(MAX_WORDS)) begin
            return WidxW'(MAX_WORDS - 1);
        end else begin
            return WidxW'(c - 32'd1);
        end
    endfunction

    // field decode
    gpc_pkg::op_t                  in_op;
    logic                          in_class;
    logic [gpc_pkg::GENO_W-1:0]    in_geno;
    logic [gpc_pkg::ROW_W-1:0]     in_row;
    logic [gpc_pkg::WIDX_W-1:0]    in_widx;
    logic [gpc_pkg::WORD_W-1:0]    in_data;
    logic [31:0]                   widx_ext;
    logic                          in_hit;
    logic                          in_last;
    logic [WidxW-1:0]              last_sel;

    assign in_op    = gpc_pkg::op_t'(s_tuser[0]);
    assign in_class = s_tuser[1];
    assign in_geno  = s_tdata[1:0];
    assign in_row   = s_tdata[13:2];
    assign in_widx  = s_tdata[23:14];
    assign in_data  = s_tdata[87:24];
    assign widx_ext = 32'(in_widx);
    assign in_hit   = widx_ext < 32'(MAX_WORDS);

    // word count registers, kept as last-word indexes
    logic [WidxW-1:0] case_last_reg, case_last_next;
    logic [WidxW-1:0] control_last_reg, control_last_next;

    always_comb begin
        case_last_next    = case_last_reg;
        control_last_next = control_last_reg;
        if (cfg_wr_en) begin
            unique case (gpc_pkg::cfg_reg_t'(cfg_index))
                gpc_pkg::REG_CASE_COUNT:    case_last_next    = last_of(cfg_wr_data);
                gpc_pkg::REG_CONTROL_COUNT: control_last_next = last_of(cfg_wr_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            case_last_reg    <= '0;
            control_last_reg <= '0;
        end else begin
            case_last_reg    <= case_last_next;
            control_last_reg <= control_last_next;
        end
    end

    assign last_sel = (in_class == gpc_pkg::CLASS_CASE) ? case_last_reg : control_last_reg;
    assign in_last  = widx_ext == 32'(last_sel);

    // transfer and store access; a load lands at its own transfer edge, so a later
    // stream read of that entry always sees it and no forwarding is needed
    gpc_pkg::acc_status_t st;
    logic                 accept;
    logic                 wr_en;
    logic                 rd_en;
    logic [AddrW-1:0]     addr;

    assign s_tready = st.adv;
    assign accept   = s_tvalid && s_tready;
    assign wr_en    = accept && (in_op == gpc_pkg::OP_LOAD) &&
                      (in_geno < gpc_pkg::GENO_COUNT) && in_hit;
    assign rd_en    = accept && (in_op == gpc_pkg::OP_STREAM);
    assign addr     = {in_class, widx_ext[WidxW-1:0]};

    logic [gpc_pkg::GENOTYPES-1:0][gpc_pkg::WORD_W-1:0] rd_data;

    gpc_store #(
        .MAX_WORDS (MAX_WORDS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_geno (in_geno),
        .wr_addr (addr),
        .wr_data (in_data),
        .rd_en   (rd_en),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

    // read stage: word and row info wait here alongside the store read
    gpc_pkg::stream_info_t       s1_info_reg, s1_info_next;
    logic [gpc_pkg::WORD_W-1:0]  s1_data_reg;

    always_comb begin
        s1_info_next.valid        = rd_en;
        s1_info_next.sample_class = in_class;
        s1_info_next.row          = in_row;
        s1_info_next.last         = in_last;
        s1_info_next.hit          = in_hit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_info_reg.valid <= 1'b0;
        end else if (st.adv) begin
            s1_info_reg <= s1_info_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            s1_data_reg <= in_data;
        end
    end

    gpc_accum u_accum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s1_info  (s1_info_reg),
        .s1_data  (s1_data_reg),
        .rd_data  (rd_data),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .status   (st)
    );

    // a fresh result comes only from a row end that advanced in the cycle before
    a_result_from_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !$past(m_tvalid && !m_tready)) |-> $past(st.emit && st.adv))
        else $error("result without a finished row");

    // a load never enters the read stage
    a_load_no_stream: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_tuser[0] == gpc_pkg::OP_LOAD)) |=> !s1_info_reg.valid)
        else $error("load word entered the stream pipeline");

    // accumulators are clear after a row end leaves
    a_acc_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (st.emit && st.adv) |=> st.acc_zero)
        else $error("accumulators not cleared after row end");

endmodule

/* verif/genotype_and_popcount_counter_unit_tb.sv */
// Self-checking testbench for the genotype and popcount counter unit.
`timescale 1ns / 1ps

module genotype_and_popcount_counter_unit_tb;
    import gpc_pkg::*;

    localparam int          MAX_WORDS    = DEF_MAX_WORDS;
    localparam int          HALF_PERIOD  = 10;
    localparam int          RESET_CYCLES = 3;
    // row end passes the read, popcount and output registers; a little margin on top
    localparam int          SETTLE       = 8;
    localparam int unsigned ITEM_TARGET  = 1350;
    // watchdog sits many times over the slowest legal run
    localparam longint      TIMEOUT_NS   = 64'd50_000_000;

    // one input transfer, field by field
    typedef struct {
        op_t               op;
        class_t            cls;
        logic [GENO_W-1:0] geno;
        logic [ROW_W-1:0]  row;
        logic [WIDX_W-1:0] widx;
        logic [WORD_W-1:0] data;
    } word_xfer_t;

    // one finished row: class, row and the three genotype cells
    typedef struct {
        class_t           cls;
        logic [ROW_W-1:0] row;
        logic [CNT_W-1:0] g0;
        logic [CNT_W-1:0] g1;
        logic [CNT_W-1:0] g2;
    } row_tally_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata     = '0;
    logic [S_TUSER_W-1:0]  s_tuser     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = REG_CASE_COUNT;
    logic [CFG_W-1:0]      cfg_wr_data = '0;

    genotype_and_popcount_counter_unit #(
        .MAX_WORDS   (MAX_WORDS)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // ---------------------------------------------------------------------------------
    // Shared state
    // ---------------------------------------------------------------------------------
    word_xfer_t  word_queue[$];        // words waiting to be driven
    row_tally_t  row_results_due[$];   // finished rows not yet seen on m_
    int unsigned mismatches   = 0;
    int unsigned queued_items = 0;     // words queued that the block acts on

    // Predictor copy of the block: second-table store, running cells, word counts.
    logic [WORD_W-1:0] geno_words [2][GENOTYPES][MAX_WORDS];
    logic [CNT_W-1:0]  tally [GENOTYPES] = '{default: '0};
    logic [CFG_W-1:0]  cfg_words [2]     = '{11'd1, 11'd1};

    // Stimulus side bookkeeping: per class, word indexes below this are loaded for
    // all three genotypes, so a streamed word there never reads an unwritten entry.
    int unsigned loaded_lim [2] = '{0, 0};

    // ---------------------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------------------
    // count in use is held to 1..MAX_WORDS
    function automatic int unsigned row_words(logic [CFG_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > MAX_WORDS)
            return MAX_WORDS;
        return 32'(v);
    endfunction

    task automatic tally_word(input word_xfer_t w);
        logic [CNT_W:0] sum;
        row_tally_t     done;
        int             g;
        if (w.op == OP_LOAD) begin
            // genotype three is dropped
            if (w.geno < GENO_COUNT)
                geno_words[w.cls][w.geno][w.widx] = w.data;
        end else begin
            for (g = 0; g < GENOTYPES; g++) begin
                sum = {1'b0, tally[g]} +
                      (CNT_W+1)'($countones(w.data & geno_words[w.cls][g][w.widx]));
                tally[g] = (sum > ACC_MAX) ? ACC_MAX : sum[CNT_W-1:0];
            end
            // row end purely on word index; order and continuity are not checked
            if (w.widx == row_words(cfg_words[w.cls]) - 1) begin
                done.cls = w.cls;
                done.row = w.row;
                done.g0  = tally[0];
                done.g1  = tally[1];
                done.g2  = tally[2];
                row_results_due.push_back(done);
                tally = '{default: '0};
            end
        end
    endtask

    // ---------------------------------------------------------------------------------
    // Idle pattern: the gap rate is picked anew at intervals so that calm stretches,
    // light gaps and heavy gaps all occur; a tenth of the gaps are long.
    // ---------------------------------------------------------------------------------
    function automatic int unsigned pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 15;
            default: return 50;
        endcase
    endfunction

    function automatic int unsigned idle_len(int unsigned pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(16, 60);
        return $urandom_range(1, 3);
    endfunction

    // ---------------------------------------------------------------------------------
    // Driver: takes words from word_queue, holds each until its transfer, and hands
    // accepted words to the predictor at the edge of the transfer.
    // ---------------------------------------------------------------------------------
    word_xfer_t  bus_word;
    int unsigned src_hold  = 0;
    int unsigned src_pct   = 15;
    int unsigned src_cycle = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            src_cycle++;
            if (src_cycle % 256 == 0)
                src_pct = pick_pct();
            if (s_tvalid && s_tready)
                tally_word(bus_word);
            if (!s_tvalid || s_tready) begin
                if (src_hold != 0) begin
                    src_hold--;
                    s_tvalid <= 1'b0;
                end else if (word_queue.size() != 0) begin
                    bus_word = word_queue.pop_front();
                    s_tdata  <= {bus_word.data, bus_word.widx, bus_word.row, bus_word.geno};
                    s_tuser  <= {bus_word.cls, bus_word.op};
                    s_tvalid <= 1'b1;
                    src_hold = idle_len(src_pct);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Monitor: every m_ transfer is matched against the oldest finished row.
    // ---------------------------------------------------------------------------------
    int unsigned snk_hold  = 0;
    int unsigned snk_pct   = 15;
    int unsigned snk_cycle = 0;

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        row_tally_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            snk_cycle++;
            if (snk_cycle % 256 == 128)
                snk_pct = pick_pct();
            if (m_tvalid && m_tready) begin
                if (row_results_due.size() == 0) begin
                    $error("row result with none due: row %0d", m_tdata[ROW_W-1:0]);
                    mismatches++;
                end else begin
                    want = row_results_due.pop_front();
                    check_field("out_class", want.cls, m_tuser);
                    check_field("out_row", want.row, m_tdata[ROW_W-1:0]);
                    check_field("count_g0", want.g0, m_tdata[ROW_W +: CNT_W]);
                    check_field("count_g1", want.g1, m_tdata[ROW_W + CNT_W +: CNT_W]);
                    check_field("count_g2", want.g2, m_tdata[ROW_W + 2*CNT_W +: CNT_W]);
                    check_field("tdata padding", '0, m_tdata[M_TDATA_W-1]);
                end
            end
            if (snk_hold != 0) begin
                snk_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                snk_hold = idle_len(snk_pct);
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------------------
    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '1;
            1:       return '0;
            2:       return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // row field is a don't-care on loads, so it is randomised to toggle its bits
    task automatic push_load(input class_t c, input logic [GENO_W-1:0] g,
                             input int unsigned w, input logic [WORD_W-1:0] d);
        word_xfer_t x;
        x.op   = OP_LOAD;
        x.cls  = c;
        x.geno = g;
        x.row  = ROW_W'($urandom_range(0, 4095));
        x.widx = WIDX_W'(w);
        x.data = d;
        word_queue.push_back(x);
        if (g < GENO_COUNT)
            queued_items++;
    endtask

    // likewise the genotype field on a streamed word
    task automatic push_stream(input class_t c, input int unsigned row,
                               input int unsigned w, input logic [WORD_W-1:0] d);
        word_xfer_t x;
        x.op   = OP_STREAM;
        x.cls  = c;
        x.geno = GENO_W'($urandom_range(0, 3));
        x.row  = ROW_W'(row);
        x.widx = WIDX_W'(w);
        x.data = d;
        word_queue.push_back(x);
        queued_items++;
    endtask

    task automatic stream_row(input class_t c, input int unsigned row, input int unsigned n);
        int unsigned w;
        for (w = 0; w < n; w++)
            push_stream(c, row, w, rand_word());
    endtask

    // load all three genotypes for the indexes a row of n words will read
    task automatic ensure_loaded(input class_t c, input int unsigned n);
        int unsigned w;
        int          g;
        for (w = loaded_lim[c]; w < n; w++)
            for (g = 0; g < GENOTYPES; g++)
                push_load(c, GENO_W'(g), w, rand_word());
        if (n > loaded_lim[c])
            loaded_lim[c] = n;
    endtask

    // all words transferred, no row due, then the pipeline allowed to empty of loads
    task automatic wait_idle();
        @(negedge aclk);
        while (word_queue.size() != 0 || s_tvalid || row_results_due.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] v);
        wait_idle();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= v;
        cfg_words[idx] = v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [CFG_W-1:0] rand_count();
        case ($urandom_range(0, 9))
            0:       return '0;                        // held up to one word
            1:       return CFG_W'($urandom_range(9, 24));
            default: return CFG_W'($urandom_range(1, 8));
        endcase
    endfunction

    // Mostly whole rows with random content; the rest is stray words, reloads,
    // dropped genotype-three loads and rows broken off early.
    task automatic random_phase();
        class_t c;
        int     pick;
        write_reg(REG_CASE_COUNT, rand_count());
        write_reg(REG_CONTROL_COUNT, rand_count());
        ensure_loaded(CLASS_CASE, row_words(cfg_words[CLASS_CASE]));
        ensure_loaded(CLASS_CONTROL, row_words(cfg_words[CLASS_CONTROL]));
        repeat (24) begin
            pick = $urandom_range(0, 9);
            c    = class_t'($urandom_range(0, 1));
            case (pick)
                6: push_stream(c, $urandom_range(0, 4095),
                               $urandom_range(0, loaded_lim[c] - 1), rand_word());
                7: push_load(c, GENO_W'($urandom_range(0, 2)),
                             $urandom_range(0, loaded_lim[c] - 1), rand_word());
                8: push_load(c, GENO_W'(3), $urandom_range(0, MAX_WORDS - 1), rand_word());
                9: stream_row(c, $urandom_range(0, 4095),
                              $urandom_range(1, row_words(cfg_words[c])));
                default: stream_row(c, $urandom_range(0, 4095), row_words(cfg_words[c]));
            endcase
        end
    endtask

    // ---------------------------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------------------------
    initial begin : stimulus
        int g;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed words at the reset counts of one word per row.
        push_load(CLASS_CASE, 0, 0, '1);
        push_load(CLASS_CASE, 1, 0, 64'h5555_5555_5555_5555);
        push_load(CLASS_CASE, 2, 0, '0);
        push_load(CLASS_CASE, 3, 0, '1);                  // genotype three: dropped
        push_load(CLASS_CONTROL, 0, 0, 64'h8000_0000_0000_0001);
        push_load(CLASS_CONTROL, 1, 0, '1);
        push_load(CLASS_CONTROL, 2, 0, 64'hAAAA_AAAA_AAAA_AAAA);
        push_stream(CLASS_CASE, 12'hFFF, 0, '1);
        push_stream(CLASS_CASE, 12'h000, 0, '0);
        push_stream(CLASS_CONTROL, 12'hFFF, 0, '1);
        push_stream(CLASS_CONTROL, 12'h555, 0, {$urandom, $urandom});
        push_load(CLASS_CASE, 2, 0, '1);                  // overwrite, read straight after
        push_stream(CLASS_CASE, 12'hAAA, 0, '1);
        for (g = 0; g < GENOTYPES; g++)
            push_load(CLASS_CONTROL, GENO_W'(g), MAX_WORDS - 1, rand_word());
        // top word index is no row end at one word: the cells keep summing
        push_stream(CLASS_CONTROL, 12'h0F0, MAX_WORDS - 1, '1);
        push_stream(CLASS_CONTROL, 12'h0F0, MAX_WORDS - 1, '1);
        push_stream(CLASS_CONTROL, 12'h00F, 0, '1);
        loaded_lim[CLASS_CASE]    = 1;
        loaded_lim[CLASS_CONTROL] = 1;

        // Short rows of different length per class, one broken off early.
        write_reg(REG_CASE_COUNT, 11'd3);
        write_reg(REG_CONTROL_COUNT, 11'd5);
        ensure_loaded(CLASS_CASE, 3);
        ensure_loaded(CLASS_CONTROL, 5);
        push_stream(CLASS_CASE, 12'h123, 0, '1);
        push_stream(CLASS_CASE, 12'h123, 1, '1);
        repeat (4) begin
            stream_row(CLASS_CASE, $urandom_range(0, 4095), 3);
            stream_row(CLASS_CONTROL, $urandom_range(0, 4095), 5);
        end

        // Longest case count ends a row only at the top index; zero count on
        // controls is held up to one.
        write_reg(REG_CASE_COUNT, 11'd1024);
        write_reg(REG_CONTROL_COUNT, 11'd0);
        for (g = 0; g < GENOTYPES; g++)
            push_load(CLASS_CASE, GENO_W'(g), MAX_WORDS - 1, rand_word());
        push_stream(CLASS_CASE, $urandom_range(0, 4095), 1, rand_word());
        push_stream(CLASS_CASE, $urandom_range(0, 4095), MAX_WORDS - 1, rand_word());
        push_stream(CLASS_CONTROL, $urandom_range(0, 4095), 0, rand_word());

        // Count of all ones in the register is held down to MAX_WORDS.
        write_reg(REG_CASE_COUNT, 11'h7FF);
        write_reg(REG_CONTROL_COUNT, 11'd1);
        push_stream(CLASS_CASE, 12'hFFF, 0, '1);
        push_stream(CLASS_CASE, 12'hFFF, MAX_WORDS - 1, '1);
        push_stream(CLASS_CONTROL, 12'h000, 0, '1);

        // Random part.
        while (queued_items < ITEM_TARGET)
            random_phase();

        wait_idle();
        if (mismatches == 0) begin
            $display("[genotype_and_popcount_counter_unit] OK");
        end else begin
            $display("[genotype_and_popcount_counter_unit] ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("[genotype_and_popcount_counter_unit] ERROR");
        $finish;
    end

endmodule

/* genotype_and_popcount_counter_unit.f */
design/gpc_pkg.sv
design/gpc_store.sv
design/gpc_accum.sv
design/genotype_and_popcount_counter_unit.sv
verif/genotype_and_popcount_counter_unit_tb.sv
